// ===== design/mcfb_pkg.sv =====
// ----------------------------------------------------------------------------
// mcfb_pkg: shared types and constants of the motor command frame builder
// Holds the command descriptor that travels from the front end to the byte
// serializer, and the field widths shared across the block.
// ----------------------------------------------------------------------------
package mcfb_pkg;

  localparam int unsigned ANGLE_W = 32;
  localparam int unsigned SPEED_W = 16;
  localparam int unsigned PPR_W   = 24;
  localparam int unsigned PULSE_W = 32;
  localparam int unsigned ACT_W   = 2;
  localparam int unsigned BYTE_W  = 8;

  localparam logic [PPR_W-1:0] PPR_RESET = 24'd32768;

  // Action codes on the command channel
  localparam logic [ACT_W-1:0] ACT_ROTATE = 2'd0;
  localparam logic [ACT_W-1:0] ACT_SPEED  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_STOP   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;

  // Command carried out by the serializer
  typedef enum logic [1:0] {
    CMD_POS,
    CMD_SPD,
    CMD_STOP
  } cmd_e;

  // One queued command: optional mode-switch frame, command, pulses or speed
  typedef struct packed {
    logic               mode_sw;
    cmd_e               cmd;
    logic [PULSE_W-1:0] data;
  } cmd_desc_t;

endpackage

// ===== design/motor_command_frame_builder_unit.sv =====
// ----------------------------------------------------------------------------
// motor_command_frame_builder_unit: motor command to serial frame builder
// Turns rotate, speed and stop commands into framed serial bytes, inserting
// a mode-switch frame whenever the drive mode has to change.
// ----------------------------------------------------------------------------
//  Channel   Direction  Payload
//  s_axis    in         tuser: action; tdata: angle, speed
//  m_axis    out        tdata: tx_byte; tuser: frame_end; tlast: run_last
//  cfg       in         cfg_data_i: pulses_per_rev
//
//  Output runs at one byte per cycle while the receiver is ready: 11, 16, 22
//  or 27 bytes per command. A rotate command holds the intake through the
//  multiply and the radix-256 divide by 360 until its descriptor is handed on.
//  Speed and stop commands go straight to the descriptor slot; a descriptor
//  queue of QUEUE_DEPTH entries lets intake and serializer stall independently.
//  Reset selects no drive mode and 32768 pulses per revolution.
// ----------------------------------------------------------------------------
module motor_command_frame_builder_unit import mcfb_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = 16,
  parameter int unsigned QUEUE_DEPTH     = 4
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  input  logic [ANGLE_W+SPEED_W-1:0] s_axis_tdata,   // angle[31:0], speed[47:32]
  input  logic [ACT_W-1:0]           s_axis_tuser,   // action[1:0]
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  output logic [BYTE_W-1:0]          m_axis_tdata,   // tx_byte[7:0]
  output logic                       m_axis_tuser,   // frame_end
  output logic                       m_axis_tlast,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [PPR_W-1:0]           cfg_data_i
);

  logic      q_push;
  logic      q_pop;
  logic      q_full;
  logic      q_empty;
  cmd_desc_t q_wr_desc;
  cmd_desc_t q_rd_desc;

  assign cfg_ready_o = 1'b1;

  mcfb_front #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .action_i   (s_axis_tuser),
    .angle_i    (s_axis_tdata[ANGLE_W-1:0]),
    .speed_i    (s_axis_tdata[ANGLE_W+SPEED_W-1:ANGLE_W]),
    .cfg_valid_i(cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .q_push_o   (q_push),
    .q_desc_o   (q_wr_desc),
    .q_full_i   (q_full)
  );

  mcfb_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .desc_i (q_wr_desc),
    .full_o (q_full),
    .pop_i  (q_pop),
    .desc_o (q_rd_desc),
    .empty_o(q_empty)
  );

  mcfb_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_desc_i       (q_rd_desc),
    .q_empty_i      (q_empty),
    .q_pop_o        (q_pop),
    .out_valid_o    (m_axis_tvalid),
    .out_ready_i    (m_axis_tready),
    .out_byte_o     (m_axis_tdata),
    .out_frame_end_o(m_axis_tuser),
    .out_run_last_o (m_axis_tlast)
  );

endmodule

// ===== design/mcfb_front.sv =====
// ----------------------------------------------------------------------------
// mcfb_front: command intake and classification
// Accepts commands, tracks the drive mode, converts angles to pulse counts
// with a multiply and a radix-256 divide by 360 whose digits come from a
// reciprocal multiply, and hands descriptors on.
// ----------------------------------------------------------------------------
module mcfb_front import mcfb_pkg::*; #(
  parameter int unsigned ANGLE_FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [ACT_W-1:0]   action_i,
  input  logic [ANGLE_W-1:0] angle_i,
  input  logic [SPEED_W-1:0] speed_i,
  input  logic               cfg_valid_i,
  input  logic [PPR_W-1:0]   cfg_data_i,
  output logic               q_push_o,
  output cmd_desc_t          q_desc_o,
  input  logic               q_full_i
);

  localparam int unsigned DEG_PER_REV = 360;
  localparam int unsigned PROD_W      = ANGLE_W + PPR_W;
  localparam int unsigned Y_W         = PROD_W - ANGLE_FRAC_BITS + 1;
  localparam int unsigned DIGIT_W     = 8;
  localparam int unsigned DIV_STEPS   = (Y_W + DIGIT_W - 1) / DIGIT_W;
  localparam int unsigned Y_PW        = DIGIT_W * DIV_STEPS;
  localparam int unsigned CNT_W       = $clog2(DIV_STEPS + 1);
  localparam int unsigned REM_W       = $clog2(DEG_PER_REV);
  localparam int unsigned T_W         = REM_W + DIGIT_W;
  localparam int unsigned EST_W       = 2 * T_W;
  localparam int unsigned RECIP_SHIFT = 25;

  localparam logic [Y_PW-1:0] HALF_REV = Y_PW'(DEG_PER_REV / 2);
  localparam logic [T_W-1:0]  DIV_1    = T_W'(DEG_PER_REV);
  // ceil(2^25 / 360): the digit estimate is exact for partial dividends below 360 * 256
  localparam logic [T_W-1:0]  RECIP    =
    T_W'((2 ** RECIP_SHIFT + DEG_PER_REV - 1) / DEG_PER_REV);

  typedef enum logic [1:0] {
    F_IDLE,
    F_MUL,
    F_DIV,
    F_DONE
  } front_state_e;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_POS,
    MODE_SPD
  } mode_e;

  front_state_e        state_q;
  mode_e               mode_q;
  logic [PPR_W-1:0]    ppr_q;
  logic                pend_valid_q;
  cmd_desc_t           pend_q;
  logic                mode_sw_q;
  logic                neg_q;
  logic [ANGLE_W-1:0]  mag_q;
  logic [Y_PW-1:0]     y_q;
  logic [REM_W-1:0]    rem_q;
  logic [PULSE_W-1:0]  quo_q;
  logic [CNT_W-1:0]    cnt_q;

  logic                pend_free;
  logic                accept;
  logic [PROD_W-1:0]   prod;
  logic [T_W-1:0]      div_t;
  logic [EST_W-1:0]    est;
  logic [T_W-1:0]      div_r;
  logic [DIGIT_W-1:0]  digit;
  logic [PULSE_W-1:0]  pulses;

  assign q_push_o   = pend_valid_q && !q_full_i;
  assign q_desc_o   = pend_q;
  assign pend_free  = !pend_valid_q || !q_full_i;
  assign in_ready_o = (state_q == F_IDLE) && pend_free;
  assign accept     = in_valid_i && in_ready_o;

  assign prod   = PROD_W'(mag_q) * PROD_W'(ppr_q);
  assign pulses = neg_q ? (PULSE_W'(0) - quo_q) : quo_q;

  // One radix-256 step of the divide by 360: estimate the digit, then the remainder
  always_comb begin
    div_t = {rem_q, y_q[Y_PW-1 -: DIGIT_W]};
    est   = EST_W'(div_t) * EST_W'(RECIP);
    digit = est[RECIP_SHIFT +: DIGIT_W];
    div_r = div_t - T_W'(digit) * DIV_1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= F_IDLE;
      mode_q       <= MODE_NONE;
      ppr_q        <= PPR_RESET;
      pend_valid_q <= 1'b0;
      pend_q       <= '0;
      mode_sw_q    <= 1'b0;
      neg_q        <= 1'b0;
      mag_q        <= '0;
      y_q          <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      cnt_q        <= '0;
    end else begin
      if (cfg_valid_i) begin
        ppr_q <= cfg_data_i;
      end
      if (q_push_o) begin
        pend_valid_q <= 1'b0;
      end
      unique case (state_q)
        F_IDLE: begin
          if (accept) begin
            case (action_i)
              ACT_ROTATE: begin
                mode_sw_q <= (mode_q != MODE_POS);
                mode_q    <= MODE_POS;
                neg_q     <= angle_i[ANGLE_W-1];
                mag_q     <= angle_i[ANGLE_W-1] ? (ANGLE_W'(0) - angle_i) : angle_i;
                state_q   <= F_MUL;
              end
              ACT_SPEED: begin
                mode_q         <= MODE_SPD;
                pend_valid_q   <= 1'b1;
                pend_q.mode_sw <= (mode_q != MODE_SPD);
                pend_q.cmd     <= CMD_SPD;
                pend_q.data    <= PULSE_W'(speed_i);
              end
              ACT_STOP: begin
                mode_q         <= MODE_SPD;
                pend_valid_q   <= 1'b1;
                pend_q.mode_sw <= (mode_q != MODE_SPD);
                pend_q.cmd     <= CMD_STOP;
                pend_q.data    <= '0;
              end
              default: begin
                // unused action code: drop the transfer
              end
            endcase
          end
        end
        F_MUL: begin
          // (prod + half divisor) / (360 << frac) == ((prod >> frac) + 180) / 360
          y_q     <= Y_PW'(prod >> ANGLE_FRAC_BITS) + HALF_REV;
          rem_q   <= '0;
          quo_q   <= '0;
          cnt_q   <= CNT_W'(DIV_STEPS);
          state_q <= F_DIV;
        end
        F_DIV: begin
          y_q   <= y_q << DIGIT_W;
          rem_q <= div_r[REM_W-1:0];
          quo_q <= {quo_q[PULSE_W-DIGIT_W-1:0], digit};
          cnt_q <= cnt_q - CNT_W'(1);
          if (cnt_q == CNT_W'(1)) begin
            state_q <= F_DONE;
          end
        end
        F_DONE: begin
          // hold until the descriptor slot frees up
          if (pend_free) begin
            pend_valid_q   <= 1'b1;
            pend_q.mode_sw <= mode_sw_q;
            pend_q.cmd     <= CMD_POS;
            pend_q.data    <= pulses;
            state_q        <= F_IDLE;
          end
        end
        default: begin
          state_q <= F_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== design/mcfb_queue.sv =====
// ----------------------------------------------------------------------------
// mcfb_queue: command descriptor queue
// Short first-word-fall-through queue between intake and serializer.
// ----------------------------------------------------------------------------
module mcfb_queue import mcfb_pkg::*; #(
  parameter int unsigned DEPTH = 4
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  cmd_desc_t desc_i,
  output logic      full_o,
  input  logic      pop_i,
  output cmd_desc_t desc_o,
  output logic      empty_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  cmd_desc_t        slot_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q;
  logic [PTR_W-1:0] rd_ptr_q;
  logic [CNT_W-1:0] count_q;

  function automatic logic [PTR_W-1:0] ptr_next(logic [PTR_W-1:0] ptr);
    return (ptr == PTR_W'(DEPTH - 1)) ? '0 : ptr + PTR_W'(1);
  endfunction

  assign full_o  = (count_q == CNT_W'(DEPTH));
  assign empty_o = (count_q == '0);
  assign desc_o  = slot_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_next(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_next(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= desc_i;
    end
  end

endmodule

// ===== design/mcfb_back.sv =====
// ----------------------------------------------------------------------------
// mcfb_back: frame serializer
// Expands each descriptor into its mode-switch and command frames, one byte per cycle
// while the receiver is ready, running CRC16-Modbus and the additive checksum on the fly.
// ----------------------------------------------------------------------------
module mcfb_back import mcfb_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cmd_desc_t         q_desc_i,
  input  logic              q_empty_i,
  output logic              q_pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [BYTE_W-1:0] out_byte_o,
  output logic              out_frame_end_o,
  output logic              out_run_last_o
);

  localparam int unsigned IDX_W = 4;

  localparam logic [IDX_W-1:0] SHORT_LAST   = 4'd10;
  localparam logic [IDX_W-1:0] POS_LAST     = 4'd15;
  localparam logic [IDX_W-1:0] CRC_FIRST    = 4'd2;
  localparam logic [IDX_W-1:0] POS_CRC_LAST = 4'd12;
  localparam logic [IDX_W-1:0] SPD_CRC_LAST = 4'd7;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  function automatic logic [15:0] crc16_byte(logic [15:0] crc, logic [BYTE_W-1:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

  // Mode-switch frames; speed differs from position in four bytes
  function automatic logic [BYTE_W-1:0] mode_frame_byte(logic spd, logic [IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      4'd0:    b = 8'hAA;
      4'd1:    b = 8'h0B;
      4'd2:    b = 8'h01;
      4'd3:    b = 8'h06;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h19;
      4'd6:    b = 8'h00;
      4'd7:    b = spd ? 8'h03 : 8'h00;
      4'd8:    b = spd ? 8'h18 : 8'h58;
      4'd9:    b = spd ? 8'h0C : 8'h0D;
      4'd10:   b = spd ? 8'hFC : 8'h3A;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] stop_byte(logic [IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      4'd0:    b = 8'hAA;
      4'd1:    b = 8'h0B;
      4'd2:    b = 8'h01;
      4'd3:    b = 8'h06;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h02;
      4'd6:    b = 8'h00;
      4'd7:    b = 8'h00;
      4'd8:    b = 8'h28;
      4'd9:    b = 8'h0A;
      4'd10:   b = 8'hF0;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] pos_hdr_byte(logic [IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      4'd0:    b = 8'hAA;
      4'd1:    b = 8'h10;
      4'd2:    b = 8'h01;
      4'd3:    b = 8'h10;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h0C;
      4'd6:    b = 8'h00;
      4'd7:    b = 8'h02;
      4'd8:    b = 8'h04;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  function automatic logic [BYTE_W-1:0] spd_hdr_byte(logic [IDX_W-1:0] idx);
    logic [BYTE_W-1:0] b;
    unique case (idx)
      4'd0:    b = 8'hAA;
      4'd1:    b = 8'h0B;
      4'd2:    b = 8'h01;
      4'd3:    b = 8'h06;
      4'd4:    b = 8'h00;
      4'd5:    b = 8'h02;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

  logic              active_q;
  cmd_desc_t         ent_q;
  logic              mode_frame_q;
  logic [IDX_W-1:0]  idx_q;
  logic [15:0]       crc_q;
  logic [BYTE_W-1:0] sum_q;
  logic              out_valid_q;
  logic [BYTE_W-1:0] out_byte_q;
  logic              out_frame_end_q;
  logic              out_run_last_q;

  logic              advance;
  logic              emit;
  logic              load;
  logic [BYTE_W-1:0] byte_c;
  logic [IDX_W-1:0]  last_idx;
  logic [IDX_W-1:0]  crc_last;
  logic              last_byte;
  logic              run_end;
  logic              in_crc;

  assign advance   = !out_valid_q || out_ready_i;
  assign emit      = active_q && advance;
  assign last_idx  = (!mode_frame_q && ent_q.cmd == CMD_POS) ? POS_LAST : SHORT_LAST;
  assign crc_last  = (ent_q.cmd == CMD_POS) ? POS_CRC_LAST : SPD_CRC_LAST;
  assign last_byte = (idx_q == last_idx);
  assign run_end   = last_byte && !mode_frame_q;
  assign in_crc    = (idx_q >= CRC_FIRST) && (idx_q <= crc_last);
  assign load      = !q_empty_i && (!active_q || (emit && run_end));
  assign q_pop_o   = load;

  always_comb begin
    if (mode_frame_q) begin
      byte_c = mode_frame_byte(ent_q.cmd != CMD_POS, idx_q);
    end else begin
      unique case (ent_q.cmd)
        CMD_POS: begin
          case (idx_q)
            4'd9:    byte_c = ent_q.data[15:8];
            4'd10:   byte_c = ent_q.data[7:0];
            4'd11:   byte_c = ent_q.data[31:24];
            4'd12:   byte_c = ent_q.data[23:16];
            4'd13:   byte_c = crc_q[7:0];
            4'd14:   byte_c = crc_q[15:8];
            4'd15:   byte_c = sum_q;
            default: byte_c = pos_hdr_byte(idx_q);
          endcase
        end
        CMD_SPD: begin
          case (idx_q)
            4'd6:    byte_c = ent_q.data[15:8];
            4'd7:    byte_c = ent_q.data[7:0];
            4'd8:    byte_c = crc_q[7:0];
            4'd9:    byte_c = crc_q[15:8];
            4'd10:   byte_c = sum_q;
            default: byte_c = spd_hdr_byte(idx_q);
          endcase
        end
        CMD_STOP: byte_c = stop_byte(idx_q);
        default:  byte_c = 8'h00;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q        <= 1'b0;
      ent_q           <= '0;
      mode_frame_q    <= 1'b0;
      idx_q           <= '0;
      crc_q           <= CRC_INIT;
      sum_q           <= '0;
      out_valid_q     <= 1'b0;
      out_byte_q      <= '0;
      out_frame_end_q <= 1'b0;
      out_run_last_q  <= 1'b0;
    end else begin
      if (emit) begin
        out_valid_q     <= 1'b1;
        out_byte_q      <= byte_c;
        out_frame_end_q <= last_byte;
        out_run_last_q  <= run_end;
        if (last_byte) begin
          if (mode_frame_q) begin
            mode_frame_q <= 1'b0;
            idx_q        <= '0;
            crc_q        <= CRC_INIT;
            sum_q        <= '0;
          end else begin
            active_q <= 1'b0;
          end
        end else begin
          idx_q <= idx_q + IDX_W'(1);
          sum_q <= sum_q + byte_c;
          if (in_crc) begin
            crc_q <= crc16_byte(crc_q, byte_c);
          end
        end
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      // chain the next descriptor straight after the last byte of a run
      if (load) begin
        active_q     <= 1'b1;
        ent_q        <= q_desc_i;
        mode_frame_q <= q_desc_i.mode_sw;
        idx_q        <= '0;
        crc_q        <= CRC_INIT;
        sum_q        <= '0;
      end
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_byte_q;
  assign out_frame_end_o = out_frame_end_q;
  assign out_run_last_o  = out_run_last_q;

endmodule

// ===== bench/mcfb_frame_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mcfb_frame_checker: scoreboard for the motor command frame builder
// Watches the command, byte and configuration channels. Every accepted
// command is turned into the serial bytes it should produce (mode switch,
// command frame, CRC16 and checksum), and every accepted byte is compared
// field by field with the oldest byte still awaited.
// ----------------------------------------------------------------------------
module mcfb_frame_checker import mcfb_pkg::*; #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_valid_i,
  input  logic                       s_ready_i,
  input  logic [ANGLE_W+SPEED_W-1:0] s_data_i,   // angle[31:0], speed[47:32]
  input  logic [ACT_W-1:0]           s_user_i,   // action[1:0]
  input  logic                       m_valid_i,
  input  logic                       m_ready_i,
  input  logic [BYTE_W-1:0]          m_data_i,   // tx_byte[7:0]
  input  logic                       m_user_i,   // frame_end
  input  logic                       m_last_i,
  input  logic                       cfg_valid_i,
  input  logic                       cfg_ready_i,
  input  logic [PPR_W-1:0]           cfg_data_i,
  output int unsigned                mismatch_count_o,
  output int unsigned                bytes_pending_o
);

  localparam int unsigned MAX_REPORTS = 100;

  typedef enum logic [1:0] {
    MODE_NONE,
    MODE_POSITION,
    MODE_SPEED
  } drive_mode_e;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              frame_end;
    logic              run_last;
  } serial_byte_t;

  // Fixed frames, padded to the longest frame length
  localparam logic [7:0] POS_MODE_FRAME [16] = '{
    8'hAA, 8'h0B, 8'h01, 8'h06, 8'h00, 8'h19, 8'h00, 8'h00,
    8'h58, 8'h0D, 8'h3A, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] SPD_MODE_FRAME [16] = '{
    8'hAA, 8'h0B, 8'h01, 8'h06, 8'h00, 8'h19, 8'h00, 8'h03,
    8'h18, 8'h0C, 8'hFC, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] STOP_FRAME [16] = '{
    8'hAA, 8'h0B, 8'h01, 8'h06, 8'h00, 8'h02, 8'h00, 8'h00,
    8'h28, 8'h0A, 8'hF0, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] POS_HEADER [16] = '{
    8'hAA, 8'h10, 8'h01, 8'h10, 8'h00, 8'h0C, 8'h00, 8'h02,
    8'h04, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};
  localparam logic [7:0] SPD_HEADER [16] = '{
    8'hAA, 8'h0B, 8'h01, 8'h06, 8'h00, 8'h02, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00};

  serial_byte_t      expected_bytes[$];
  logic [PPR_W-1:0]  pulses_per_rev;
  drive_mode_e       drive_mode;
  int unsigned       mismatches = 0;

  function automatic logic [15:0] frame_crc16(input logic [7:0] fb [16], input int first,
                                              input int count);
    logic [15:0] crc;
    crc = 16'hFFFF;
    for (int i = first; i < first + count; i++) begin
      crc = crc ^ {8'h00, fb[i]};
      for (int k = 0; k < 8; k++) begin
        crc = crc[0] ? ((crc >> 1) ^ 16'hA001) : (crc >> 1);
      end
    end
    return crc;
  endfunction

  function automatic logic [7:0] byte_sum(input logic [7:0] fb [16], input int count);
    logic [7:0] sum;
    sum = 8'h00;
    for (int i = 0; i < count; i++) begin
      sum = sum + fb[i];
    end
    return sum;
  endfunction

  // Round half away from zero of angle * ppr / 360, wrapped to 32 bits
  function automatic logic [PULSE_W-1:0] pulse_count(input logic [ANGLE_W-1:0] ang,
                                                     input logic [PPR_W-1:0] ppr);
    logic        neg;
    logic [63:0] mag;
    logic [63:0] prod;
    logic [63:0] den;
    logic [63:0] quo;
    neg  = ang[ANGLE_W-1];
    mag  = {32'd0, neg ? (~ang + 32'd1) : ang};
    prod = mag * {40'd0, ppr};
    den  = 64'd360 << FRAC_BITS;
    quo  = (prod + (den >> 1)) / den;
    return neg ? (~quo[31:0] + 32'd1) : quo[31:0];
  endfunction

  task automatic queue_frame(input logic [7:0] fb [16], input int len);
    serial_byte_t sb;
    for (int i = 0; i < len; i++) begin
      sb.data      = fb[i];
      sb.frame_end = (i == len - 1);
      sb.run_last  = 1'b0;
      expected_bytes.insert(expected_bytes.size(), sb);
    end
  endtask

  task automatic predict_command(input logic [ACT_W-1:0] action,
                                 input logic [ANGLE_W-1:0] angle,
                                 input logic [SPEED_W-1:0] speed);
    logic [7:0]         fb [16];
    logic [PULSE_W-1:0] pulses;
    logic [15:0]        crc;
    int                 start_count;
    start_count = expected_bytes.size();
    case (action)
      ACT_ROTATE: begin
        if (drive_mode != MODE_POSITION) begin
          queue_frame(POS_MODE_FRAME, 11);
          drive_mode = MODE_POSITION;
        end
        pulses = pulse_count(angle, pulses_per_rev);
        fb     = POS_HEADER;
        // word-swapped: low word first, each word high byte first
        fb[9]  = pulses[15:8];
        fb[10] = pulses[7:0];
        fb[11] = pulses[31:24];
        fb[12] = pulses[23:16];
        crc    = frame_crc16(fb, 2, 11);
        fb[13] = crc[7:0];
        fb[14] = crc[15:8];
        fb[15] = byte_sum(fb, 15);
        queue_frame(fb, 16);
      end
      ACT_SPEED, ACT_STOP: begin
        if (drive_mode != MODE_SPEED) begin
          queue_frame(SPD_MODE_FRAME, 11);
          drive_mode = MODE_SPEED;
        end
        if (action == ACT_SPEED) begin
          fb     = SPD_HEADER;
          fb[6]  = speed[15:8];
          fb[7]  = speed[7:0];
          crc    = frame_crc16(fb, 2, 6);
          fb[8]  = crc[7:0];
          fb[9]  = crc[15:8];
          fb[10] = byte_sum(fb, 10);
          queue_frame(fb, 11);
        end else begin
          queue_frame(STOP_FRAME, 11);
        end
      end
      default: begin
        // unused action code: drop the command
      end
    endcase
    if (expected_bytes.size() > start_count) begin
      expected_bytes[expected_bytes.size() - 1].run_last = 1'b1;
    end
  endtask

  task automatic report_mismatch(input string msg);
    if (mismatches < MAX_REPORTS) begin
      $display("%0t ns: %s", $time, msg);
    end
    mismatches++;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    serial_byte_t want;
    if (!rst_ni) begin
      expected_bytes.delete();
      pulses_per_rev  = PPR_RESET;
      drive_mode      = MODE_NONE;
      bytes_pending_o <= 0;
    end else begin
      if (m_valid_i && m_ready_i) begin
        if (expected_bytes.size() == 0) begin
          report_mismatch($sformatf("byte %02h arrived with none pending", m_data_i));
        end else begin
          want = expected_bytes.pop_front();
          if (m_data_i !== want.data) begin
            report_mismatch($sformatf("tx_byte %02h, want %02h", m_data_i, want.data));
          end
          if (m_user_i !== want.frame_end) begin
            report_mismatch($sformatf("frame_end %b, want %b (byte %02h)",
                                      m_user_i, want.frame_end, want.data));
          end
          if (m_last_i !== want.run_last) begin
            report_mismatch($sformatf("run_last %b, want %b (byte %02h)",
                                      m_last_i, want.run_last, want.data));
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        pulses_per_rev = cfg_data_i;
      end
      if (s_valid_i && s_ready_i) begin
        predict_command(s_user_i, s_data_i[ANGLE_W-1:0], s_data_i[ANGLE_W+SPEED_W-1:ANGLE_W]);
      end
      bytes_pending_o <= expected_bytes.size();
    end
    mismatch_count_o <= mismatches;
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: top of the motor command frame builder testbench
// Drives rotate, speed, stop and unused commands with random gaps and
// receiver stalls, including one long receiver hold-off, and steps the
// pulses-per-revolution register through its extremes between phases.
// The frame checker beside the block predicts and compares every byte.
// ----------------------------------------------------------------------------
module testbench import mcfb_pkg::*; ();

  localparam int unsigned FRAC_BITS       = 16;
  localparam int unsigned WATCHDOG_LIMIT  = 3000;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned PRESSURE_CYCLES = 400;
  localparam int unsigned PHASE_ITEMS     = 40;
  localparam int unsigned NUM_PHASES      = 5;

  logic                       clk_i;
  logic                       rst_ni;
  logic                       s_axis_tvalid;
  logic                       s_axis_tready;
  logic [ANGLE_W+SPEED_W-1:0] s_axis_tdata;   // angle[31:0], speed[47:32]
  logic [ACT_W-1:0]           s_axis_tuser;   // action[1:0]
  logic                       m_axis_tvalid;
  logic                       m_axis_tready;
  logic [BYTE_W-1:0]          m_axis_tdata;   // tx_byte[7:0]
  logic                       m_axis_tuser;   // frame_end
  logic                       m_axis_tlast;
  logic                       cfg_valid_i;
  logic                       cfg_ready_o;
  logic [PPR_W-1:0]           cfg_data_i;

  int unsigned bytes_pending;
  int unsigned mismatch_count;
  int unsigned tx_gap_pct  = 0;
  int unsigned rx_gap_pct  = 0;
  int unsigned rx_hold_req = 0;

  motor_command_frame_builder_unit #(
    .ANGLE_FRAC_BITS(FRAC_BITS)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  mcfb_frame_checker #(
    .FRAC_BITS(FRAC_BITS)
  ) u_frame_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_valid_i       (s_axis_tvalid),
    .s_ready_i       (s_axis_tready),
    .s_data_i        (s_axis_tdata),
    .s_user_i        (s_axis_tuser),
    .m_valid_i       (m_axis_tvalid),
    .m_ready_i       (m_axis_tready),
    .m_data_i        (m_axis_tdata),
    .m_user_i        (m_axis_tuser),
    .m_last_i        (m_axis_tlast),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .mismatch_count_o(mismatch_count),
    .bytes_pending_o (bytes_pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // Byte receiver: long hold-off on request, otherwise random stall bursts
  initial begin
    int unsigned hold_left;
    int unsigned gap_left;
    int unsigned hold_seen;
    hold_left = 0;
    gap_left  = 0;
    hold_seen = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rx_hold_req != hold_seen) begin
        hold_seen = rx_hold_req;
        hold_left = PRESSURE_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (gap_left != 0) begin
        gap_left--;
        m_axis_tready <= 1'b0;
      end else if ($urandom_range(0, 99) < rx_gap_pct) begin
        gap_left = $urandom_range(0, 12);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // End the run once nothing has moved on any channel for too long
  initial begin
    int unsigned quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles++;
      end
    end
    $display("testbench NOT OK");
    $finish;
  end

  task automatic send_command(input logic [ACT_W-1:0] action, input logic [ANGLE_W-1:0] angle,
                              input logic [SPEED_W-1:0] speed);
    int unsigned gap;
    gap = ($urandom_range(0, 99) < tx_gap_pct) ? $urandom_range(1, 13) : 0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= {speed, angle};
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Hold off until every awaited byte is out and the intake has settled
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (bytes_pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_ppr(input logic [PPR_W-1:0] value);
    wait_drained();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [ANGLE_W-1:0] random_angle();
    logic [ANGLE_W-1:0] mag;
    logic               neg;
    neg = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 9))
      0, 1, 2, 3: mag = $urandom();
      4, 5:       mag = ($urandom_range(0, 1440) << FRAC_BITS) | $urandom_range(0, 65535);
      6: begin
        case ($urandom_range(0, 3))
          0:       mag = 32'h7FFF_FFFF;
          1:       mag = 32'h8000_0000;
          2:       mag = 32'h0000_0000;
          default: mag = 32'hFFFF_FFFF;
        endcase
        neg = 1'b0;
      end
      // multiples of 360 raw units land on exact half steps at some settings
      7:          mag = $urandom_range(0, 4000) * 360;
      default:    mag = $urandom_range(0, 20'hFFFFF);
    endcase
    return neg ? (~mag + 32'd1) : mag;
  endfunction

  initial begin
    logic [ACT_W-1:0] action;
    logic [PPR_W-1:0] ppr_value;
    int unsigned      sent;
    int unsigned      pick;

    rst_ni        <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= '0;
    cfg_valid_i   <= 1'b0;
    cfg_data_i    <= '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed commands at the reset setting
    tx_gap_pct = 20;
    rx_gap_pct = 20;
    send_command(ACT_STOP, 32'h0, 16'h0);             // stop from no mode
    send_command(ACT_SPEED, 32'h0, 16'h7FFF);
    send_command(ACT_SPEED, 32'hFFFF_FFFF, 16'h8000);
    send_command(ACT_SPEED, 32'h0, 16'hFFFF);
    send_command(ACT_ROTATE, 32'h0, 16'h0);           // switch to position
    send_command(ACT_ROTATE, 32'h7FFF_FFFF, 16'hFFFF);
    send_command(ACT_ROTATE, 32'h8000_0000, 16'h0);
    send_command(ACT_ROTATE, 32'hFFFF_FFFF, 16'h0);
    send_command(ACT_ROTATE, 32'd360, 16'h0);         // exactly half a pulse
    send_command(ACT_ROTATE, -32'sd360, 16'h0);
    send_command(ACT_ROTATE, 32'd360 << FRAC_BITS, 16'h0);
    send_command(ACT_UNUSED, 32'hA5A5_5A5A, 16'h1234);
    send_command(ACT_ROTATE, 32'd1, 16'h0);
    send_command(ACT_STOP, 32'h0, 16'h0);             // switch back to speed
    send_command(ACT_STOP, 32'h0, 16'h0);
    send_command(ACT_SPEED, 32'h0, 16'h0000);
    send_command(ACT_UNUSED, 32'hFFFF_FFFF, 16'hFFFF);
    send_command(ACT_ROTATE, 32'd1 << FRAC_BITS, 16'h0);
    send_command(ACT_SPEED, 32'h0, 16'h0001);
    send_command(ACT_ROTATE, -(32'sd1 << FRAC_BITS), 16'h0);

    for (int phase = 0; phase < NUM_PHASES; phase++) begin
      case (phase)
        0:       ppr_value = 24'hFF_FFFF;
        1:       ppr_value = 24'd1;
        2:       ppr_value = 24'd0;
        3:       ppr_value = PPR_W'($urandom_range(2, 24'hFF_FFFF));
        default: ppr_value = PPR_RESET;
      endcase
      write_ppr(ppr_value);
      case (phase)
        0: begin
          tx_gap_pct = 30;
          rx_gap_pct = 30;
          // long receiver hold-off so the descriptor queue fills
          rx_hold_req++;
        end
        1: begin
          tx_gap_pct = 0;
          rx_gap_pct = 0;
        end
        2: begin
          tx_gap_pct = 50;
          rx_gap_pct = 15;
        end
        3: begin
          tx_gap_pct = 15;
          rx_gap_pct = 50;
        end
        default: begin
          tx_gap_pct = 0;
          rx_gap_pct = 0;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          action = ACT_ROTATE;
        end else if (pick < 70) begin
          action = ACT_SPEED;
        end else if (pick < 93) begin
          action = ACT_STOP;
        end else begin
          action = ACT_UNUSED;
        end
        send_command(action, random_angle(), 16'($urandom()));
        if (action != ACT_UNUSED) begin
          sent++;
        end
      end
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

// ===== motor_command_frame_builder_unit.f =====
design/mcfb_pkg.sv
design/mcfb_front.sv
design/mcfb_queue.sv
design/mcfb_back.sv
design/motor_command_frame_builder_unit.sv
bench/mcfb_frame_checker.sv
bench/testbench.sv
